/* hdl/usm_pkg.sv */
// shared types, constants and arithmetic helpers for the unsharp mask stream
`default_nettype none
package usm_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = 16;
	localparam int FW_W = 12;
	localparam int STR_W = 10;
	localparam logic [STR_W-1:0] STR_MAX = STR_W'(512);
	localparam int PADDR_W = 4;
	// line store entry: original pixel, blur of row y-2, blur of row y-1
	localparam int MEM_W = 32 + 24 + 24;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	// up to three inputs in flight, four results each
	localparam int ROOM_LIMIT = FIFO_DEPTH - 12;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_STRENGTH,
		REG_NONE
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic [10:0] column;
		logic [15:0] line_number;
		logic last_of_run;
	} result_t;

	typedef struct packed {
		logic [FW_W-1:0] width;
		logic [ROW_W-1:0] height;
	} geom_t;

	// one column of work for the line store
	typedef struct packed {
		logic [COL_W-1:0] k;
		logic [31:0] orig;
		logic [23:0] hk;
		logic [ROW_W-1:0] y;
		logic lastrow;
		logic first;
		logic last;
	} job_t;

	// result before sharpening
	typedef struct packed {
		logic [31:0] pix;
		logic [23:0] blur;
		logic [COL_W-1:0] x;
		logic [ROW_W-1:0] y;
		logic last;
	} rslt_t;

	typedef struct packed {
		logic [2:0] vld;
		rslt_t [2:0] ent;
	} push_t;

	function automatic logic [23:0] blur3(input logic [23:0] a, input logic [23:0] b,
		input logic [23:0] c);
		logic [23:0] r;
		logic [9:0] v;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			v = {2'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8], 1'b0} + {2'b0, c[8*i +: 8]} + 10'd2;
			r[8*i +: 8] = v[9:2];
		end
		return r;
	endfunction

	function automatic logic [7:0] sharpen(input logic [7:0] o, input logic [7:0] b,
		input logic [STR_W-1:0] s);
		logic signed [8:0] d;
		logic signed [19:0] p;
		logic signed [20:0] t;
		logic signed [20:0] t2;
		logic [12:0] q;
		d = $signed({1'b0, o}) - $signed({1'b0, b});
		p = $signed({1'b0, s}) * d;
		t = $signed({5'd0, o, 8'd0}) + $signed({p[19], p});
		t2 = t + 21'sd128;
		q = t2[20:8];
		if (t[20])
			return 8'd0;
		else if (q > 13'd255)
			return 8'd255;
		else
			return q[7:0];
	endfunction

endpackage
`default_nettype wire

/* hdl/usm_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module usm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* hdl/usm_front.sv */
// input side: raster position, pixel window, horizontal blur, column jobs
`default_nettype none
module usm_front import usm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	input wire pixel_t pix,
	output logic pix_stall,
	input wire geom_t geom,
	input wire logic room,
	output job_t job,
	output logic job_valid
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [31:0] win0_q, win1_q;
	job_t j0_q, jb_q;
	logic j0_vld_q, jb_vld_q;

	logic acc;
	logic [31:0] cur;
	logic [COL_W-1:0] x;
	logic rowend, lastrow, has_a;
	logic [31:0] left_a, left_b;
	job_t job_a, job_b;

	assign pix_stall = jb_vld_q || !room;
	assign acc = pix_valid && !pix_stall;
	assign cur = {pix.alpha, pix.blue, pix.green, pix.red};

	always_comb begin
		if ({1'b0, col_q} >= geom.width)
			x = COL_W'(geom.width - FW_W'(1));
		else
			x = col_q;
		rowend = ({1'b0, x} + FW_W'(1)) >= geom.width;
		lastrow = ({1'b0, row_q} + 17'd1) >= {1'b0, geom.height};
		has_a = (x != '0);
		left_a = (x == COL_W'(1)) ? win0_q : win1_q;
		left_b = has_a ? win0_q : cur;

		job_a.k = x - COL_W'(1);
		job_a.orig = win0_q;
		job_a.hk = blur3(left_a[23:0], win0_q[23:0], cur[23:0]);
		job_a.y = row_q;
		job_a.lastrow = lastrow;
		job_a.first = rowend;
		job_a.last = !rowend;

		job_b.k = x;
		job_b.orig = cur;
		job_b.hk = blur3(left_b[23:0], cur[23:0], cur[23:0]);
		job_b.y = row_q;
		job_b.lastrow = lastrow;
		job_b.first = 1'b0;
		job_b.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			win0_q <= '0;
			win1_q <= '0;
			j0_vld_q <= 1'b0;
			jb_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				win1_q <= win0_q;
				win0_q <= cur;
				if (rowend) begin
					col_q <= '0;
					row_q <= lastrow ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= x + COL_W'(1);
				end
				j0_vld_q <= has_a || rowend;
				jb_vld_q <= has_a && rowend;
			end else if (jb_vld_q) begin
				j0_vld_q <= 1'b1;
				jb_vld_q <= 1'b0;
			end else begin
				j0_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			j0_q <= has_a ? job_a : job_b;
			jb_q <= job_b;
		end else if (jb_vld_q) begin
			j0_q <= jb_q;
		end
	end

	assign job = j0_q;
	assign job_valid = j0_vld_q;

endmodule
`default_nettype wire

/* hdl/usm_core.sv */
// line store read-modify-write and vertical blur, emits ordered results
`default_nettype none
module usm_core import usm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire job_t job,
	input wire logic job_valid,
	output push_t push
);

	job_t s1_q;
	logic s1_vld_q;
	logic fwd_hit_q;
	logic [MEM_W-1:0] fwd_q;
	rslt_t hold_q;
	logic hold_vld_q;

	logic [MEM_W-1:0] ram_rdata, rd, wdata;
	logic [31:0] prev;
	logic [23:0] older, newer, up;
	rslt_t ra, rb;
	logic ra_ok, rb_ok;
	rslt_t [2:0] cand;
	logic [2:0] cv;
	logic [1:0] n;

	usm_ram #(.WIDTH(MEM_W), .DEPTH(MAX_WIDTH)) u_line (
		.clk(clk),
		.we(s1_vld_q),
		.waddr(s1_q.k),
		.wdata(wdata),
		.raddr(job.k),
		.rdata(ram_rdata)
	);

	always_comb begin
		// write landing on the same edge as this read is forwarded
		rd = fwd_hit_q ? fwd_q : ram_rdata;
		prev = rd[79:48];
		older = rd[47:24];
		newer = rd[23:0];
		up = (s1_q.y != '0) ? newer : s1_q.hk;

		ra_ok = (s1_q.y != '0);
		ra.pix = prev;
		ra.blur = blur3(older, newer, s1_q.hk);
		ra.x = s1_q.k;
		ra.y = s1_q.y - ROW_W'(1);
		ra.last = 1'b0;

		rb_ok = s1_q.lastrow;
		rb.pix = s1_q.orig;
		rb.blur = blur3(up, s1_q.hk, s1_q.hk);
		rb.x = s1_q.k;
		rb.y = s1_q.y;
		rb.last = 1'b0;

		wdata = {s1_q.orig, (s1_q.y == '0) ? s1_q.hk : newer, s1_q.hk};

		// previous row first: first column of a pair defers its own-row result
		cand[0] = ra;
		cand[1] = hold_q;
		cand[2] = rb;
		cv[0] = ra_ok;
		cv[1] = !s1_q.first && hold_vld_q;
		cv[2] = !s1_q.first && rb_ok;

		push = '0;
		n = '0;
		for (int i = 0; i < 3; i++) begin
			if (s1_vld_q && cv[i]) begin
				push.ent[n] = cand[i];
				push.vld[n] = 1'b1;
				n = n + 2'd1;
			end
		end
		if (s1_q.last && n != '0)
			push.ent[n - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			fwd_hit_q <= 1'b0;
			hold_vld_q <= 1'b0;
		end else begin
			s1_vld_q <= job_valid;
			fwd_hit_q <= job_valid && s1_vld_q && (s1_q.k == job.k);
			if (s1_vld_q && s1_q.first)
				hold_vld_q <= rb_ok;
			else if (s1_vld_q)
				hold_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		s1_q <= job;
		fwd_q <= wdata;
		if (s1_vld_q && s1_q.first)
			hold_q <= rb;
	end

endmodule
`default_nettype wire

/* hdl/usm_outq.sv */
// result queue, sharpening and output register
`default_nettype none
module usm_outq import usm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire push_t push,
	input wire logic [STR_W-1:0] strength,
	output logic room,
	output logic res_valid,
	output result_t res,
	input wire logic res_stall
);

	rslt_t mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0] count_q;
	logic res_vld_q;
	result_t res_q;

	logic pop;
	logic [1:0] npush;
	rslt_t head;

	assign npush = 2'($countones(push.vld));
	assign pop = (count_q != '0) && (!res_vld_q || !res_stall);
	assign room = count_q <= (FIFO_AW+1)'(ROOM_LIMIT);
	assign head = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			wptr_q <= wptr_q + FIFO_AW'(npush);
			if (pop)
				rptr_q <= rptr_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW+1)'(npush) - (FIFO_AW+1)'(pop);
			if (pop)
				res_vld_q <= 1'b1;
			else if (!res_stall)
				res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (push.vld[i])
				mem[wptr_q + FIFO_AW'(i)] <= push.ent[i];
		end
		if (pop) begin
			res_q.out_red <= sharpen(head.pix[7:0], head.blur[7:0], strength);
			res_q.out_green <= sharpen(head.pix[15:8], head.blur[15:8], strength);
			res_q.out_blue <= sharpen(head.pix[23:16], head.blur[23:16], strength);
			res_q.out_alpha <= head.pix[31:24];
			res_q.column <= head.x;
			res_q.line_number <= head.y;
			res_q.last_of_run <= head.last;
		end
	end

	assign res_valid = res_vld_q;
	assign res = res_q;

endmodule
`default_nettype wire

/* hdl/binomial_unsharp_mask_stream.sv */
// top level: configuration registers and the sharpening pipeline
// Usage:
// Pixels enter in raster order on pix/pix_valid; a beat is taken when
// pix_valid is high and pix_stall low. Results leave on res/res_valid
// under res_stall, each tagged with its column and line number; row y-1
// comes out while row y streams in, and the last row also emits its own
// results. An input causes zero to four results; last_of_run marks the
// final one. Throughput is one pixel per cycle while the queue has room,
// but the end of a row wider than one pixel holds the input while two
// columns go through the single line store port, one after the other.
// Results wait in a 16-entry queue; pix_stall rises when the queue can no
// longer cover the results of the beats in flight, so a stalled receiver
// backs up the input within a few beats. Reset clears position counters,
// pipeline and queue; line store contents are left as they are. Program
// frame_width, frame_height and strength over the register port while
// the stream is idle.
`default_nettype none
module binomial_unsharp_mask_stream import usm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	input wire pixel_t pix,
	output logic pix_stall,
	output logic res_valid,
	output result_t res,
	input wire logic res_stall,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [FW_W-1:0] fw_q;
	logic [ROW_W-1:0] fh_q;
	logic [STR_W-1:0] str_q;

	reg_idx_t idx;
	geom_t geom;
	logic [STR_W-1:0] str_eff;
	logic room;
	job_t job;
	logic job_valid;
	push_t push;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_W'(1);
			fh_q <= ROW_W'(1);
			str_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_FRAME_WIDTH: fw_q <= pwdata[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[ROW_W-1:0];
				REG_STRENGTH: str_q <= pwdata[STR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRAME_WIDTH: prdata = {20'd0, fw_q};
			REG_FRAME_HEIGHT: prdata = {16'd0, fh_q};
			REG_STRENGTH: prdata = {22'd0, str_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		if (fw_q == '0)
			geom.width = FW_W'(1);
		else if (fw_q > FW_W'(MAX_WIDTH))
			geom.width = FW_W'(MAX_WIDTH);
		else
			geom.width = fw_q;
		geom.height = (fh_q == '0) ? ROW_W'(1) : fh_q;
		str_eff = (str_q > STR_MAX) ? STR_MAX : str_q;
	end

	usm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix(pix),
		.pix_stall(pix_stall),
		.geom(geom),
		.room(room),
		.job(job),
		.job_valid(job_valid)
	);

	usm_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.job(job),
		.job_valid(job_valid),
		.push(push)
	);

	usm_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.strength(str_eff),
		.room(room),
		.res_valid(res_valid),
		.res(res),
		.res_stall(res_stall)
	);

endmodule
`default_nettype wire

/* hdl/usm_checker.sv */
// port-level checks for the unsharp mask stream, bound to the top level
`default_nettype none
module usm_checker import usm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire result_t res,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata
);

	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result beat during reset");

	a_width_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == 4'd0 ##1 psel && !pwrite && paddr == 4'd0
		|-> prdata[11:0] == $past(pwdata[11:0]))
		else $error("frame width readback mismatch");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("stalled result beat changed");

endmodule

bind binomial_unsharp_mask_stream usm_checker u_usm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res(res),
	.psel(psel),
	.penable(penable),
	.pwrite(pwrite),
	.paddr(paddr),
	.pwdata(pwdata),
	.prdata(prdata)
);
`default_nettype wire

/* test/binomial_unsharp_mask_stream_check.sv */
// checker for the unsharp mask stream: predicts results from pixel beats and compares
`default_nettype none
module binomial_unsharp_mask_stream_check import usm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	input wire logic pix_stall,
	input wire pixel_t pix,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire result_t res,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic pready,
	input wire logic [PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output int errors,
	output int pending,
	output int results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] pix;
		logic [23:0] blur;
		int x;
		int y;
	} column_out_t;

	logic [31:0] row_pixels [MAX_WIDTH];
	logic [23:0] blur_older [MAX_WIDTH];
	logic [23:0] blur_newer [MAX_WIDTH];
	logic [31:0] window0, window1;
	int col_pos, row_pos;
	logic [FW_W-1:0] width_reg;
	logic [ROW_W-1:0] height_reg;
	logic [STR_W-1:0] gain_reg;

	result_t sharpened_q [$];
	column_out_t above_q [$];
	column_out_t here_q [$];

	function automatic logic [23:0] kernel3(input logic [23:0] a, input logic [23:0] b,
		input logic [23:0] c);
		logic [23:0] r;
		int v;
		for (int k = 0; k < 3; k++) begin
			v = (int'(a[8*k +: 8]) + 2 * int'(b[8*k +: 8]) + int'(c[8*k +: 8]) + 2) >> 2;
			r[8*k +: 8] = v[7:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] boost(input logic [7:0] o, input logic [7:0] b, input int s);
		int t, q;
		t = int'(o) * 256 + s * (int'(o) - int'(b));
		if (t < 0)
			return 8'd0;
		q = (t + 128) / 256;
		return (q > 255) ? 8'd255 : q[7:0];
	endfunction

	task automatic line_column(input int k, input logic [31:0] orig, input logic [23:0] hk,
		input int y, input bit lastrow);
		column_out_t c;
		if (y >= 1) begin
			c.pix = row_pixels[k];
			c.blur = kernel3(blur_older[k], blur_newer[k], hk);
			c.x = k;
			c.y = y - 1;
			above_q.push_back(c);
		end
		if (lastrow) begin
			c.pix = orig;
			c.blur = kernel3((y >= 1) ? blur_newer[k] : hk, hk, hk);
			c.x = k;
			c.y = y;
			here_q.push_back(c);
		end
		blur_older[k] = (y == 0) ? hk : blur_newer[k];
		blur_newer[k] = hk;
		row_pixels[k] = orig;
	endtask

	task automatic predict_pixel(input pixel_t p);
		logic [31:0] cur;
		logic [23:0] hk;
		int w, h, s, x, y, n;
		bit rowend, lastrow;
		column_out_t c;
		result_t r;
		cur = {p.alpha, p.blue, p.green, p.red};
		w = (width_reg == 0) ? 1 : int'(width_reg);
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		h = (height_reg == 0) ? 1 : int'(height_reg);
		s = (gain_reg > STR_MAX) ? int'(STR_MAX) : int'(gain_reg);
		x = col_pos;
		y = row_pos;
		if (x >= w)
			x = w - 1;
		rowend = (x + 1 >= w);
		lastrow = (y + 1 >= h);
		above_q.delete();
		here_q.delete();
		if (x >= 1) begin
			hk = kernel3((x == 1) ? window0[23:0] : window1[23:0], window0[23:0], cur[23:0]);
			line_column(x - 1, window0, hk, y, lastrow);
		end
		if (rowend) begin
			hk = kernel3((x >= 1) ? window0[23:0] : cur[23:0], cur[23:0], cur[23:0]);
			line_column(x, cur, hk, y, lastrow);
		end
		window1 = window0;
		window0 = cur;
		if (rowend) begin
			col_pos = 0;
			row_pos = lastrow ? 0 : y + 1;
		end else begin
			col_pos = x + 1;
		end
		n = above_q.size() + here_q.size();
		for (int i = 0; i < n; i++) begin
			c = (i < above_q.size()) ? above_q[i] : here_q[i - above_q.size()];
			r.out_red = boost(c.pix[7:0], c.blur[7:0], s);
			r.out_green = boost(c.pix[15:8], c.blur[15:8], s);
			r.out_blue = boost(c.pix[23:16], c.blur[23:16], s);
			r.out_alpha = c.pix[31:24];
			r.column = c.x[10:0];
			r.line_number = c.y[15:0];
			r.last_of_run = (i == n - 1);
			sharpened_q.push_back(r);
		end
	endtask

	assign pending = sharpened_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			window0 <= '0;
			window1 <= '0;
			col_pos <= 0;
			row_pos <= 0;
			width_reg <= FW_W'(1);
			height_reg <= ROW_W'(1);
			gain_reg <= '0;
			errors <= 0;
			results_seen <= 0;
			sharpened_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_FRAME_WIDTH: width_reg <= pwdata[FW_W-1:0];
					REG_FRAME_HEIGHT: height_reg <= pwdata[ROW_W-1:0];
					REG_STRENGTH: gain_reg <= pwdata[STR_W-1:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				results_seen <= results_seen + 1;
				if (sharpened_q.size() == 0) begin
					$display("%0t: unexpected result beat %p", $time, res);
					errors <= errors + 1;
				end else begin
					want = sharpened_q.pop_front();
					if (res !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, res);
						errors <= errors + 1;
					end
				end
			end
			// prediction after the pop so this beat's results never match themselves
			if (pix_valid && !pix_stall)
				predict_pixel(pix);
		end
	end
endmodule
`default_nettype wire

/* test/binomial_unsharp_mask_stream_test.sv */
// top of the unsharp mask stream testbench: clock, stimulus and verdict
`default_nettype none
module binomial_unsharp_mask_stream_test;
	import usm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PIXELS = 300;

	logic clk, arst_n;
	logic pix_valid, pix_stall, res_valid, res_stall;
	pixel_t pix;
	result_t res;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	int errors, pending, results_seen;
	int cycles, pixels_sent, random_sent;
	bit quiet;

	binomial_unsharp_mask_stream uut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix(pix), .pix_stall(pix_stall),
		.res_valid(res_valid), .res(res), .res_stall(res_stall),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	binomial_unsharp_mask_stream_check check (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at %0t with %0d results outstanding", $time, pending);
			$display("binomial_unsharp_mask_stream_test: FAIL");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	initial begin
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(1, 20)) @(negedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// a row can end with no result in flight, so let the pipe drain past its latency
	task automatic wait_drained();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_geometry(input int w, input int h, input int s);
		wait_drained();
		reg_write(REG_FRAME_WIDTH, w);
		reg_write(REG_FRAME_HEIGHT, h);
		reg_write(REG_STRENGTH, s);
	endtask

	function automatic logic [7:0] pick_level(input bit extremes);
		if (extremes && $urandom_range(0, 2) != 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom());
	endfunction

	// entered at a falling edge; leaves valid high so beats can follow back to back
	task automatic send_pixel(input bit extremes);
		pixel_t p;
		p.red = pick_level(extremes);
		p.green = pick_level(extremes);
		p.blue = pick_level(extremes);
		p.alpha = pick_level(extremes);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (pix_stall);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_pixels(input int count, input bit extremes);
		for (int i = 0; i < count; i++)
			send_pixel(extremes);
		pix_valid <= 1'b0;
	endtask

	initial begin
		int w, h;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		pixels_sent = 0;
		random_sent = 0;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: single pixel frames, gain zero
		send_pixels(3, 1'b1);
		// zero width and height act as one, gain above the top saturates
		set_geometry(0, 0, 1023);
		send_pixels(3, 1'b1);
		set_geometry(4, 3, 512);
		send_pixels(12, 1'b1);
		set_geometry(1, 5, 300);
		send_pixels(5, 1'b1);
		// tallest frame cut short, then ended by lowering the height mid-frame
		set_geometry(5, 65535, 128);
		send_pixels(10, 1'b1);
		set_geometry(5, 2, 128);
		send_pixels(5, 1'b1);
		// widest row, and a width beyond the line store that clamps to it,
		// each ended early by lowering the width mid-row
		set_geometry(2048, 1, 256);
		send_pixels(40, 1'b0);
		set_geometry(41, 1, 256);
		send_pixels(1, 1'b0);
		set_geometry(4095, 1, 64);
		send_pixels(40, 1'b0);
		set_geometry(30, 1, 64);
		send_pixels(1, 1'b0);

		while (random_sent < RANDOM_PIXELS) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 5);
			set_geometry(w, h, ($urandom_range(0, 7) == 0) ? $urandom_range(513, 1023)
				: $urandom_range(0, 512));
			send_pixels(w * h, $urandom_range(0, 3) == 0);
			random_sent += w * h;
			if (random_sent > RANDOM_PIXELS * 4 / 5)
				quiet = 1'b1;
		end

		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("sent %0d pixels over directed and random frame shapes, checked %0d results",
			pixels_sent, results_seen);
		if (errors == 0)
			$display("binomial_unsharp_mask_stream_test: PASS");
		else
			$display("binomial_unsharp_mask_stream_test: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
